// ----- hw/rtl/mouse_packet_position_tracker_unit_macros.svh -----
// Assertion helpers shared by the tracker modules.
// Both expect a clock named i_clk in scope; MPT_ASSERT also needs an active-low reset named i_rst_n.
`ifndef MOUSE_PACKET_POSITION_TRACKER_UNIT_MACROS_SVH
`define MOUSE_PACKET_POSITION_TRACKER_UNIT_MACROS_SVH

// Checked only while the block is out of reset.
`define MPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MPT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mpt_pkg.sv -----
package mpt_pkg;

    localparam int unsigned COORD_BITS_DEF = 12;

    // Command codes carried in tuser.
    localparam logic [2:0] CMD_BYTE   = 3'd0;
    localparam logic [2:0] CMD_REPORT = 3'd1;
    localparam logic [2:0] CMD_MARK   = 3'd2;
    localparam logic [2:0] CMD_FORGET = 3'd3;
    localparam logic [2:0] CMD_INIT   = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_TASKBAR = 2'd2;
    localparam logic [1:0] REG_PLEN    = 2'd3;

    localparam logic [12:0] RST_WIDTH   = 13'd1024;
    localparam logic [12:0] RST_HEIGHT  = 13'd768;
    localparam logic [7:0]  RST_TASKBAR = 8'd28;
    localparam logic [2:0]  RST_PLEN    = 3'd4;

    localparam logic [2:0] PLEN_LONG  = 3'd4;
    localparam logic [1:0] LAST_LONG  = 2'd3;
    localparam logic [1:0] LAST_SHORT = 2'd2;

    localparam logic [7:0] BUTTON_MASK = 8'h07;

    localparam int unsigned IN_TDATA_W = 40;
    localparam int unsigned IN_TUSER_W = 3;
    localparam int unsigned APB_AW     = 4;
    localparam int unsigned APB_DW     = 32;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [7:0]  taskbar;
        logic [2:0]  plen;
    } t_cfg;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic       from_aux;
        logic [7:0] report_dx;
        logic [7:0] report_dy;
        logic [7:0] report_buttons;
    } t_item;

    typedef struct packed {
        logic byte_dropped;
        logic packet_done;
        logic moved;
    } t_flags;

    // Half of a screen dimension, saturated to the coordinate range.
    function automatic logic [16:0] sat_half(input logic [12:0] v, input int unsigned cb);
        logic [16:0] h;
        logic [16:0] m;
        h = {5'b0, v[12:1]};
        m = 17'((17'd1 << cb) - 17'd1);
        return (h > m) ? m : h;
    endfunction

endpackage

// ----- hw/rtl/mpt_cfg_regs.sv -----
module mpt_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpt_pkg::APB_AW-1:0]      paddr,
    input  logic [mpt_pkg::APB_DW-1:0]      pwdata,
    output logic [mpt_pkg::APB_DW-1:0]      prdata,
    output logic                            pready,
    output mpt_pkg::t_cfg                   o_cfg
);

    mpt_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width   <= mpt_pkg::RST_WIDTH;
            r_cfg.height  <= mpt_pkg::RST_HEIGHT;
            r_cfg.taskbar <= mpt_pkg::RST_TASKBAR;
            r_cfg.plen    <= mpt_pkg::RST_PLEN;
        end else if (wr_en) begin
            unique case (reg_idx)
                mpt_pkg::REG_WIDTH:   r_cfg.width   <= pwdata[12:0];
                mpt_pkg::REG_HEIGHT:  r_cfg.height  <= pwdata[12:0];
                mpt_pkg::REG_TASKBAR: r_cfg.taskbar <= pwdata[7:0];
                mpt_pkg::REG_PLEN:    r_cfg.plen    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mpt_pkg::REG_WIDTH:   prdata = {19'b0, r_cfg.width};
            mpt_pkg::REG_HEIGHT:  prdata = {19'b0, r_cfg.height};
            mpt_pkg::REG_TASKBAR: prdata = {24'b0, r_cfg.taskbar};
            mpt_pkg::REG_PLEN:    prdata = {29'b0, r_cfg.plen};
            default:              prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/mpt_core.sv -----
`include "mouse_packet_position_tracker_unit_macros.svh"

module mpt_core #(
    parameter int unsigned COORD_BITS = mpt_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  mpt_pkg::t_item        i_item,
    input  mpt_pkg::t_cfg         i_cfg,
    output logic [COORD_BITS-1:0] o_pos_x,
    output logic [COORD_BITS-1:0] o_pos_y,
    output logic [7:0]            o_buttons,
    output mpt_pkg::t_flags       o_flags
);

    localparam int unsigned CB = COORD_BITS;
    localparam logic [16:0] CMAX17 = 17'((1 << CB) - 1);
    localparam logic [16:0] RST_X17 = mpt_pkg::sat_half(mpt_pkg::RST_WIDTH, CB);
    localparam logic [16:0] RST_Y17 = mpt_pkg::sat_half(mpt_pkg::RST_HEIGHT, CB);

    logic [CB-1:0] r_cur_x, n_cur_x;
    logic [CB-1:0] r_cur_y, n_cur_y;
    logic [CB-1:0] r_drawn_x, n_drawn_x;
    logic [CB-1:0] r_drawn_y, n_drawn_y;
    logic          r_drawn_valid, n_drawn_valid;
    logic [7:0]    r_buttons, n_buttons;
    logic [1:0]    r_byte_idx, n_byte_idx;
    logic [7:0]    r_pend_flags, n_pend_flags;
    logic [7:0]    r_pend_dx, n_pend_dx;
    logic [7:0]    r_pend_dy, n_pend_dy;

    logic              move_en;
    logic [7:0]        mdx;
    logic [7:0]        mdy;
    logic [1:0]        last_idx;
    logic              done;
    logic              dropped;
    logic [12:0]       w_m1;
    logic [12:0]       y_diff;
    logic [16:0]       xmax17;
    logic [16:0]       ymax17;
    logic [CB-1:0]     xmax;
    logic [CB-1:0]     ymax;
    logic signed [CB+1:0] x_sum;
    logic signed [CB+1:0] y_sum;
    logic [CB-1:0]     clamp_x;
    logic [CB-1:0]     clamp_y;
    logic [16:0]       init_x17;
    logic [16:0]       init_y17;

    // Clamp bounds follow the live configuration registers.
    always_comb begin
        w_m1   = (i_cfg.width == 13'd0) ? 13'd0 : i_cfg.width - 13'd1;
        xmax17 = ({4'b0, w_m1} > CMAX17) ? CMAX17 : {4'b0, w_m1};
        y_diff = i_cfg.height - {5'b0, i_cfg.taskbar} - 13'd1;
        ymax17 = (i_cfg.height > {5'b0, i_cfg.taskbar}) ? {4'b0, y_diff} : 17'd0;
        if (ymax17 > CMAX17) begin
            ymax17 = CMAX17;
        end
        xmax     = xmax17[CB-1:0];
        ymax     = ymax17[CB-1:0];
        init_x17 = mpt_pkg::sat_half(i_cfg.width, CB);
        init_y17 = mpt_pkg::sat_half(i_cfg.height, CB);
    end

    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_drawn_x     = r_drawn_x;
        n_drawn_y     = r_drawn_y;
        n_drawn_valid = r_drawn_valid;
        n_buttons     = r_buttons;
        n_byte_idx    = r_byte_idx;
        n_pend_flags  = r_pend_flags;
        n_pend_dx     = r_pend_dx;
        n_pend_dy     = r_pend_dy;
        move_en       = 1'b0;
        mdx           = r_pend_dx;
        mdy           = r_pend_dy;
        done          = 1'b0;
        dropped       = 1'b0;
        last_idx = (i_cfg.plen >= mpt_pkg::PLEN_LONG) ? mpt_pkg::LAST_LONG
                                                      : mpt_pkg::LAST_SHORT;

        unique case (i_item.cmd)
            mpt_pkg::CMD_BYTE: begin
                if (r_byte_idx == 2'd0 && !i_item.from_aux) begin
                    dropped = 1'b1;
                end else begin
                    case (r_byte_idx)
                        2'd0:    n_pend_flags = i_item.data_byte;
                        2'd1:    n_pend_dx    = i_item.data_byte;
                        2'd2:    n_pend_dy    = i_item.data_byte;
                        default: ;
                    endcase
                    if (r_byte_idx >= last_idx) begin
                        move_en    = 1'b1;
                        mdx        = n_pend_dx;
                        mdy        = n_pend_dy;
                        n_buttons  = n_pend_flags & mpt_pkg::BUTTON_MASK;
                        n_byte_idx = 2'd0;
                        done       = 1'b1;
                    end else begin
                        n_byte_idx = r_byte_idx + 2'd1;
                    end
                end
            end
            mpt_pkg::CMD_REPORT: begin
                move_en   = 1'b1;
                mdx       = i_item.report_dx;
                mdy       = i_item.report_dy;
                n_buttons = i_item.report_buttons;
                done      = 1'b1;
            end
            mpt_pkg::CMD_MARK: begin
                n_drawn_x     = r_cur_x;
                n_drawn_y     = r_cur_y;
                n_drawn_valid = 1'b1;
            end
            mpt_pkg::CMD_FORGET: begin
                n_drawn_valid = 1'b0;
            end
            mpt_pkg::CMD_INIT: begin
                n_cur_x       = init_x17[CB-1:0];
                n_cur_y       = init_y17[CB-1:0];
                n_drawn_valid = 1'b0;
                n_buttons     = 8'd0;
                n_byte_idx    = 2'd0;
                n_pend_flags  = 8'd0;
                n_pend_dx     = 8'd0;
                n_pend_dy     = 8'd0;
            end
            default: ;
        endcase

        // One shared add and clamp serves both packets and direct reports.
        // Screen y grows downward, so an upward delta is subtracted.
        x_sum = $signed({2'b00, r_cur_x}) + $signed({{(CB-6){mdx[7]}}, mdx});
        y_sum = $signed({2'b00, r_cur_y}) - $signed({{(CB-6){mdy[7]}}, mdy});
        if (x_sum < 0) begin
            clamp_x = '0;
        end else if (x_sum > $signed({2'b00, xmax})) begin
            clamp_x = xmax;
        end else begin
            clamp_x = x_sum[CB-1:0];
        end
        if (y_sum < 0) begin
            clamp_y = '0;
        end else if (y_sum > $signed({2'b00, ymax})) begin
            clamp_y = ymax;
        end else begin
            clamp_y = y_sum[CB-1:0];
        end
        if (move_en) begin
            n_cur_x = clamp_x;
            n_cur_y = clamp_y;
        end
    end

    assign o_pos_x              = n_cur_x;
    assign o_pos_y              = n_cur_y;
    assign o_buttons            = n_buttons;
    assign o_flags.moved        = !n_drawn_valid || (n_cur_x != n_drawn_x)
                                  || (n_cur_y != n_drawn_y);
    assign o_flags.packet_done  = done;
    assign o_flags.byte_dropped = dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= RST_X17[CB-1:0];
            r_cur_y       <= RST_Y17[CB-1:0];
            r_drawn_x     <= '0;
            r_drawn_y     <= '0;
            r_drawn_valid <= 1'b0;
            r_buttons     <= 8'd0;
            r_byte_idx    <= 2'd0;
            r_pend_flags  <= 8'd0;
            r_pend_dx     <= 8'd0;
            r_pend_dy     <= 8'd0;
        end else if (i_step) begin
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_drawn_x     <= n_drawn_x;
            r_drawn_y     <= n_drawn_y;
            r_drawn_valid <= n_drawn_valid;
            r_buttons     <= n_buttons;
            r_byte_idx    <= n_byte_idx;
            r_pend_flags  <= n_pend_flags;
            r_pend_dx     <= n_pend_dx;
            r_pend_dy     <= n_pend_dy;
        end
    end

    `MPT_ASSERT(a_packet_end_rewinds, i_step && i_item.cmd == mpt_pkg::CMD_BYTE && done |=> r_byte_idx == 2'd0, "byte index not rewound after a packet")
    `MPT_ASSERT(a_move_inside_x, i_step && move_en |=> r_cur_x <= $past(xmax), "x left its clamp range")

endmodule

// ----- hw/rtl/mouse_packet_position_tracker_unit.sv -----
// Mouse packet position tracker.
// The slave stream carries one request per cycle: tuser holds the command
// (controller byte, direct delta report, mark drawn, forget drawn, init) and
// tdata holds the byte, its auxiliary-port flag and the direct report fields.
// The master stream returns exactly one result per request: the clamped
// position, the button state and the moved, packet-done and byte-dropped flags.
// Screen width, height, taskbar rows and packet length sit behind an APB port
// whose pready is always high; write them only while no request is in flight.
// A request is captured in an input register, runs through one add-and-clamp
// stage into the result register, and is visible on the master side from
// there. A new request is taken every cycle while the receiver takes results;
// the position add and clamp and its bound arithmetic lie between the registers.
// When the receiver stalls, the result register holds its result and the
// input register can still hold one more request; ready drops only when both
// are full. Reset empties both registers, restores the register defaults and
// recenters the cursor with nothing drawn.
`include "mouse_packet_position_tracker_unit_macros.svh"

module mouse_packet_position_tracker_unit #(
    parameter int unsigned COORD_BITS = mpt_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata from bit 0: data_byte[7:0], from_aux[8], report_dx[16:9],
    // report_dy[24:17], report_buttons[32:25], zero fill above.
    input  logic [mpt_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // tuser: cmd[2:0].
    input  logic [mpt_pkg::IN_TUSER_W-1:0]      i_s_tuser,
    // Result stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata from bit 0: pos_x, pos_y (COORD_BITS each), button_bits (8),
    // moved, packet_done, byte_dropped, zero fill up to whole bytes.
    output logic [((2*COORD_BITS+11+7)/8)*8-1:0] o_m_tdata,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mpt_pkg::APB_AW-1:0]          paddr,
    input  logic [mpt_pkg::APB_DW-1:0]          pwdata,
    output logic [mpt_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    localparam int unsigned OUT_TW = ((2*COORD_BITS+11+7)/8)*8;

    mpt_pkg::t_cfg   cfg;
    mpt_pkg::t_item  r_in;
    logic            r_in_valid;
    logic            adv;

    logic [COORD_BITS-1:0] core_x;
    logic [COORD_BITS-1:0] core_y;
    logic [7:0]            core_buttons;
    mpt_pkg::t_flags       core_flags;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic [7:0]            r_out_buttons;
    mpt_pkg::t_flags       r_out_flags;

    mpt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The held request moves on whenever the result register is free or is
    // being emptied in this cycle; the tracker state commits at that edge.
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in.cmd            <= i_s_tuser[2:0];
            r_in.data_byte      <= i_s_tdata[7:0];
            r_in.from_aux       <= i_s_tdata[8];
            r_in.report_dx      <= i_s_tdata[16:9];
            r_in.report_dy      <= i_s_tdata[24:17];
            r_in.report_buttons <= i_s_tdata[32:25];
        end
    end

    mpt_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (adv),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_pos_x   (core_x),
        .o_pos_y   (core_y),
        .o_buttons (core_buttons),
        .o_flags   (core_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_x       <= core_x;
            r_out_y       <= core_y;
            r_out_buttons <= core_buttons;
            r_out_flags   <= core_flags;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TW'({r_out_flags, r_out_buttons, r_out_y, r_out_x});

    `MPT_ASSERT(a_done_or_drop, o_m_tvalid |-> !(r_out_flags.packet_done && r_out_flags.byte_dropped), "result both completed and dropped")
    `MPT_ASSERT_RST(a_reset_empties, !i_rst_n |=> !o_m_tvalid && !r_in_valid, "registers not empty after reset")

endmodule

// ----- verif/mouse_packet_position_tracker_unit_checker.sv -----
module mouse_packet_position_tracker_unit_checker
    import mpt_pkg::*;
#(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF,
    parameter int unsigned OUT_W      = ((2*COORD_BITS+11+7)/8)*8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,
    input  logic [IN_TUSER_W-1:0] i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_W-1:0]      i_m_tdata,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_AW-1:0]     i_paddr,
    input  logic [APB_DW-1:0]     i_pwdata,
    input  logic [APB_DW-1:0]     i_prdata,
    input  logic                  i_pready,
    output int                    o_errors,
    output int                    o_backlog
);

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct {
        t_coord     x;
        t_coord     y;
        logic [7:0] buttons;
        logic       moved;
        logic       done;
        logic       dropped;
    } t_cursor_report;

    t_cfg           screen_cfg;
    t_coord         cur_x;
    t_coord         cur_y;
    t_coord         drawn_x;
    t_coord         drawn_y;
    logic           drawn_valid;
    logic [7:0]     held_buttons;
    logic [1:0]     byte_idx;
    logic [7:0]     pend_flags;
    logic [7:0]     pend_dx;
    logic [7:0]     pend_dy;
    t_cursor_report reports_due[$];
    int             mismatch_count = 0;

    function automatic int saturate_coord(input int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    function automatic void restore_after_reset();
        screen_cfg.width   = RST_WIDTH;
        screen_cfg.height  = RST_HEIGHT;
        screen_cfg.taskbar = RST_TASKBAR;
        screen_cfg.plen    = RST_PLEN;
        cur_x        = t_coord'(saturate_coord(int'(RST_WIDTH) / 2));
        cur_y        = t_coord'(saturate_coord(int'(RST_HEIGHT) / 2));
        drawn_x      = '0;
        drawn_y      = '0;
        drawn_valid  = 1'b0;
        held_buttons = '0;
        byte_idx     = '0;
        pend_flags   = '0;
        pend_dx      = '0;
        pend_dy      = '0;
    endfunction

    // Moves the cursor and clamps it to the visible area above the taskbar.
    function automatic void shift_cursor(input int dx, input int dy);
        int nx;
        int ny;
        int xmax;
        int ymax;
        nx = int'(cur_x) + dx;
        ny = int'(cur_y) - dy;
        xmax = (screen_cfg.width == 0) ? 0 : int'(screen_cfg.width) - 1;
        ymax = (int'(screen_cfg.height) > int'(screen_cfg.taskbar))
             ? int'(screen_cfg.height) - int'(screen_cfg.taskbar) - 1 : 0;
        xmax = saturate_coord(xmax);
        ymax = saturate_coord(ymax);
        if (nx < 0) nx = 0;
        if (ny < 0) ny = 0;
        if (nx > xmax) nx = xmax;
        if (ny > ymax) ny = ymax;
        cur_x = t_coord'(nx);
        cur_y = t_coord'(ny);
    endfunction

    function automatic void predict_request(input logic [IN_TUSER_W-1:0] cmd,
                                            input logic [IN_TDATA_W-1:0] bits);
        t_cursor_report rep;
        logic [1:0]     last_idx;
        rep.done    = 1'b0;
        rep.dropped = 1'b0;
        case (cmd)
            CMD_BYTE: begin
                last_idx = (screen_cfg.plen >= PLEN_LONG) ? LAST_LONG : LAST_SHORT;
                if (byte_idx == 0 && !bits[8]) begin
                    rep.dropped = 1'b1;
                end else begin
                    case (byte_idx)
                        2'd0: pend_flags = bits[7:0];
                        2'd1: pend_dx = bits[7:0];
                        2'd2: pend_dy = bits[7:0];
                        default: ;
                    endcase
                    if (byte_idx >= last_idx) begin
                        shift_cursor(int'($signed(pend_dx)), int'($signed(pend_dy)));
                        held_buttons = pend_flags & BUTTON_MASK;
                        byte_idx = '0;
                        rep.done = 1'b1;
                    end else begin
                        byte_idx = byte_idx + 2'd1;
                    end
                end
            end
            CMD_REPORT: begin
                shift_cursor(int'($signed(bits[16:9])), int'($signed(bits[24:17])));
                held_buttons = bits[32:25];
                rep.done = 1'b1;
            end
            CMD_MARK: begin
                drawn_x = cur_x;
                drawn_y = cur_y;
                drawn_valid = 1'b1;
            end
            CMD_FORGET: begin
                drawn_valid = 1'b0;
            end
            CMD_INIT: begin
                cur_x = t_coord'(saturate_coord(int'(screen_cfg.width) / 2));
                cur_y = t_coord'(saturate_coord(int'(screen_cfg.height) / 2));
                drawn_valid  = 1'b0;
                held_buttons = '0;
                byte_idx     = '0;
                pend_flags   = '0;
                pend_dx      = '0;
                pend_dy      = '0;
            end
            default: ;
        endcase
        rep.x       = cur_x;
        rep.y       = cur_y;
        rep.buttons = held_buttons;
        rep.moved   = !drawn_valid || cur_x != drawn_x || cur_y != drawn_y;
        reports_due.push_back(rep);
    endfunction

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_report(input logic [OUT_W-1:0] bits);
        t_cursor_report want;
        if (reports_due.size() == 0) begin
            $error("result 0x%0h arrived with no request waiting", bits);
            mismatch_count++;
            return;
        end
        want = reports_due.pop_front();
        compare_field("pos_x", want.x, bits[COORD_BITS-1:0]);
        compare_field("pos_y", want.y, bits[2*COORD_BITS-1:COORD_BITS]);
        compare_field("button_bits", want.buttons, bits[2*COORD_BITS+7:2*COORD_BITS]);
        compare_field("moved", want.moved, bits[2*COORD_BITS+8]);
        compare_field("packet_done", want.done, bits[2*COORD_BITS+9]);
        compare_field("byte_dropped", want.dropped, bits[2*COORD_BITS+10]);
    endfunction

    function automatic logic [APB_DW-1:0] setting_value(input logic [1:0] index);
        case (index)
            REG_WIDTH:   return APB_DW'(screen_cfg.width);
            REG_HEIGHT:  return APB_DW'(screen_cfg.height);
            REG_TASKBAR: return APB_DW'(screen_cfg.taskbar);
            default:     return APB_DW'(screen_cfg.plen);
        endcase
    endfunction

    function automatic void write_setting(input logic [1:0] index,
                                          input logic [APB_DW-1:0] value);
        case (index)
            REG_WIDTH:   screen_cfg.width   = value[12:0];
            REG_HEIGHT:  screen_cfg.height  = value[12:0];
            REG_TASKBAR: screen_cfg.taskbar = value[7:0];
            default:     screen_cfg.plen    = value[2:0];
        endcase
    endfunction

    // A result leaves only after its request has been registered, so the oldest
    // expectation is retired before this edge's request is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_after_reset();
            reports_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_report(i_m_tdata);
            if (i_s_tvalid && i_s_tready) predict_request(i_s_tuser, i_s_tdata);
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    write_setting(i_paddr[3:2], i_pwdata);
                end else begin
                    compare_field("prdata", setting_value(i_paddr[3:2]), i_prdata);
                end
            end
        end
        o_backlog <= reports_due.size();
        o_errors  <= mismatch_count;
    end

endmodule

// ----- verif/mouse_packet_position_tracker_unit_test.sv -----
module mouse_packet_position_tracker_unit_test;
    import mpt_pkg::*;

    localparam int unsigned OUT_W = ((2*COORD_BITS_DEF+11+7)/8)*8;

    // This limit sits well above what a correct run needs, so it only trips
    // when the block hangs.
    localparam int CYCLE_LIMIT      = 400000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 125;

    // Command codes above init are undefined and must leave the state alone.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_TDATA_W-1:0] i_s_tdata = '0;
    logic [IN_TUSER_W-1:0] i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int   mismatches;
    int   backlog;
    int   cycle_count = 0;

    // Stimulus-side bookkeeping. The sender mirrors where the block stands in
    // packet assembly so that well-formed packets start on a packet boundary.
    int   packet_bytes = 4;
    int   stream_pos = 0;
    int   idle_pct = 20;

    // Flags that steer the receiver process; the sender sets the first two.
    logic quiet_tail = 1'b0;
    logic long_hold_req = 1'b0;
    logic long_hold_done = 1'b0;

    mouse_packet_position_tracker_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // The checker watches both streams and the configuration port, predicts
    // every result and compares it; this module only makes stimulus.
    mouse_packet_position_tracker_unit_checker #(
        .COORD_BITS (COORD_BITS_DEF),
        .OUT_W      (OUT_W)
    ) position_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .o_errors   (mismatches),
        .o_backlog  (backlog)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hang guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL mouse_packet_position_tracker_unit");
            $finish;
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Request tdata, from bit 0: data_byte, from_aux, report_dx, report_dy,
    // report_buttons, zero fill.
    function automatic logic [IN_TDATA_W-1:0] pack_request(input logic [7:0] value,
                                                           input logic       aux,
                                                           input logic [7:0] dx,
                                                           input logic [7:0] dy,
                                                           input logic [7:0] btn);
        return {{(IN_TDATA_W-33){1'b0}}, btn, dy, dx, aux, value};
    endfunction

    // Offers one request and holds it until the block takes it. The valid
    // stays high into the next request unless a random idle burst follows.
    task automatic offer_request(input logic [2:0] cmd, input logic [IN_TDATA_W-1:0] bits);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= bits;
        do @(posedge i_clk); while (!o_s_tready);
        if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Controller byte. The fields that only direct reports use carry noise.
    task automatic send_port_byte(input logic [7:0] value, input logic aux);
        offer_request(CMD_BYTE, pack_request(value, aux, any_byte(), any_byte(), any_byte()));
        // A non-auxiliary byte at packet start is dropped and does not advance.
        if (stream_pos != 0 || aux) begin
            stream_pos = (stream_pos + 1 >= packet_bytes) ? 0 : stream_pos + 1;
        end
    endtask

    task automatic send_report(input logic [7:0] dx, input logic [7:0] dy,
                               input logic [7:0] btn);
        offer_request(CMD_REPORT, pack_request(any_byte(), any_bit(), dx, dy, btn));
    endtask

    // Commands without operands: every data field is random.
    task automatic send_plain(input logic [2:0] cmd);
        offer_request(cmd, pack_request(any_byte(), any_bit(), any_byte(), any_byte(),
                                        any_byte()));
        if (cmd == CMD_INIT) stream_pos = 0;
    endtask

    // Stops offering and waits until every expected result has been taken
    // and the pipeline has settled.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (backlog != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One APB transfer. psel stays up so that transfers can run back to back;
    // the caller lowers it after the last one.
    task automatic apb_access(input logic write, input logic [1:0] index,
                              input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Writes all four registers while the block is idle and reads them back.
    task automatic program_screen(input logic [12:0] width, input logic [12:0] height,
                                  input logic [7:0] taskbar, input logic [2:0] plen);
        wait_drained();
        apb_access(1'b1, REG_WIDTH, APB_DW'(width));
        apb_access(1'b1, REG_HEIGHT, APB_DW'(height));
        apb_access(1'b1, REG_TASKBAR, APB_DW'(taskbar));
        apb_access(1'b1, REG_PLEN, APB_DW'(plen));
        apb_access(1'b0, REG_WIDTH, '0);
        apb_access(1'b0, REG_HEIGHT, '0);
        apb_access(1'b0, REG_TASKBAR, '0);
        apb_access(1'b0, REG_PLEN, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        packet_bytes = (plen >= PLEN_LONG) ? 4 : 3;
    endtask

    // Mostly whole packets with random content, mixed with direct reports,
    // drawn-position commands, recenters, stray bytes and undefined commands.
    task automatic play_random_phase(input int count);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // Finish any partial packet first, then send one whole packet.
                while (stream_pos != 0) begin
                    send_port_byte(any_byte(), any_bit());
                    sent++;
                end
                send_port_byte(any_byte(), 1'b1);
                for (n = 1; n < packet_bytes; n++) send_port_byte(any_byte(), any_bit());
                sent += packet_bytes;
            end else if (pick < 70) begin
                send_report(any_byte(), any_byte(), any_byte());
                sent++;
            end else if (pick < 76) begin
                send_plain(CMD_MARK);
                sent++;
            end else if (pick < 81) begin
                send_plain(CMD_FORGET);
                sent++;
            end else if (pick < 84) begin
                send_plain(CMD_INIT);
                sent++;
            end else if (pick < 95) begin
                // Stray or broken run of bytes; at packet start a non-auxiliary byte is dropped.
                n = $urandom_range(1, 3);
                repeat (n) send_port_byte(any_byte(), any_bit());
                sent += n;
            end else begin
                // Undefined commands leave the tracker state alone and are not counted.
                send_plain(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)));
            end
        end
    endtask

    // Result side: random stalls and ready stretches, one long hold-off that
    // fills the block until it stalls the request side, and steady ready in
    // the closing phase.
    initial begin : result_sink
        @(posedge i_clk);
        forever begin
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (quiet_tail) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        i_m_tready <= 1'b0;
                        repeat ($urandom_range(1, 18)) @(posedge i_clk);
                    end
                    1: begin
                        i_m_tready <= 1'b1;
                        repeat ($urandom_range(20, 60)) @(posedge i_clk);
                    end
                    default: begin
                        i_m_tready <= 1'b1;
                        repeat ($urandom_range(1, 18)) @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        int          phase;
        int          tb_cap;
        logic [12:0] w;
        logic [12:0] h;
        logic [7:0]  tb;
        logic [2:0]  pl;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings: 1024 x 768, 28 taskbar rows,
        // four-byte packets.
        send_plain(CMD_SPARE_FIRST);
        send_plain(CMD_SPARE_LAST);
        send_port_byte(8'h00, 1'b0);            // non-auxiliary byte at start: dropped
        send_port_byte(8'hFF, 1'b1);            // flags with every bit set, masked to the three button bits
        send_port_byte(8'h7F, 1'b0);            // dx = +127
        send_port_byte(8'h80, 1'b0);            // dy = -128, so y grows
        send_port_byte(8'hAA, 1'b1);            // fourth byte, ignored, ends the packet
        send_plain(CMD_MARK);                   // position now matches the drawn one
        send_report(8'h00, 8'h00, 8'hFF);       // no motion, unmasked buttons
        send_report(8'h80, 8'h7F, 8'h00);
        send_plain(CMD_FORGET);
        send_plain(CMD_INIT);
        // Leave a four-byte packet three bytes in, then shorten the packet.
        send_port_byte(8'h08, 1'b1);
        send_port_byte(8'h01, 1'b0);
        send_port_byte(8'hFF, 1'b1);

        // One-pixel-wide screen with a height not above the taskbar and three-byte
        // packets; the next byte ends the packet.
        program_screen(13'd1, 13'd2, 8'd255, 3'd3);
        send_port_byte(8'h55, 1'b0);
        send_report(8'h7F, 8'h80, 8'h01);
        send_plain(CMD_INIT);                   // recenter is not clamped to the screen
        send_plain(CMD_MARK);
        send_report(8'h00, 8'h00, 8'h02);       // the clamp alone moves the cursor

        // Bounds beyond the coordinate range saturate; length above four acts as four.
        program_screen(13'h1FFF, 13'h1FFF, 8'd0, 3'd7);
        send_plain(CMD_INIT);
        send_report(8'h7F, 8'h80, 8'h04);
        send_report(8'h80, 8'h7F, 8'h00);

        // Zero width pins x to the left edge; length zero acts as three.
        program_screen(13'd0, 13'd4096, 8'd255, 3'd0);
        send_port_byte(8'hF8, 1'b1);
        send_port_byte(8'h10, 1'b0);
        send_port_byte(8'h10, 1'b1);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0: begin
                    w = 13'($urandom_range(1, 40));
                    h = 13'($urandom_range(2, 40));
                end
                1: begin
                    w = 13'($urandom_range(0, 8191));
                    h = 13'($urandom_range(0, 8191));
                end
                default: begin
                    w = 13'($urandom_range(1, 4096));
                    h = 13'($urandom_range(2, 4096));
                end
            endcase
            tb_cap = (h > 13'd256) ? 255 : int'(h) - 1;
            if (tb_cap < 0) tb_cap = 0;
            tb = ($urandom_range(0, 3) == 0) ? any_byte() : 8'($urandom_range(0, tb_cap));
            if ($urandom_range(0, 4) == 0) begin
                pl = 3'($urandom_range(0, 7));
            end else begin
                pl = any_bit() ? PLEN_LONG : 3'd3;
            end
            program_screen(w, h, tb, pl);

            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            if (phase == 1) long_hold_req <= 1'b1;
            if (phase == RANDOM_PHASES - 1) quiet_tail <= 1'b1;
            play_random_phase(ITEMS_PER_PHASE);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && backlog == 0) begin
            $display("PASS mouse_packet_position_tracker_unit");
        end else begin
            $display("FAIL mouse_packet_position_tracker_unit");
        end
        $finish;
    end

endmodule
